FILE: rtl/drrip_pkg.sv
// drrip_pkg: shared constants and types for the dead-block drrip replacement block
// no dependencies
`timescale 1ns / 1ps

package drrip_pkg;

   localparam int NumSets      = 2048;
   localparam int NumWays      = 16;
   localparam int LeaderSets   = 32;
   localparam int SelectorBits = 10;

   localparam int SetBits  = $clog2(NumSets);
   localparam int WayBits  = $clog2(NumWays);
   localparam int RowBits  = 2 * NumWays;

   localparam logic [1:0] RrpvMax    = 2'd3;
   localparam logic [1:0] NearInsert = 2'd2;
   localparam logic [1:0] LiveMax    = 2'd3;

   localparam logic [SelectorBits-1:0] PselMax  = {SelectorBits{1'b1}};
   localparam logic [SelectorBits-1:0] PselHalf = PselMax >> 1;
   localparam logic [15:0]             DecayReset = 16'd4096;

   localparam logic CmdVictim = 1'b0;
   localparam logic CmdUpdate = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [SetBits-1:0]  set_index;
      logic [WayBits-1:0]  way_index;
      logic                hit;
      logic [4:0]          random_draw;
   } req_type;

   typedef struct packed {
      logic [WayBits-1:0]      victim_way;
      logic                    victim_was_dead;
      logic [SelectorBits-1:0] policy_select;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch request
      logic rd_row;    // issue row read at request set
      logic latch_row; // latch read data
      logic age;       // age latched row once
      logic commit;    // write row back, update selector and fill counter
      logic sweep_rd;  // issue decay read at sweep address
      logic sweep_wr;  // write decremented or cleared row at sweep address
      logic sweep_inc; // advance sweep address
      logic load_out;  // register result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic found;      // latched row has a victim
      logic decay_due;  // commit caused a decay
      logic sweep_last; // sweep address is at last set
   } sts_type;

endpackage

FILE: rtl/drrip_if.sv
// drrip_if: valid/ready channel interfaces for the request, response and csr payloads
// depends on drrip_pkg for payload types
`timescale 1ns / 1ps

interface drrip_req_if;
   import drrip_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface drrip_rsp_if;
   import drrip_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface drrip_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/drrip_ram.sv
// drrip_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module drrip_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

FILE: rtl/drrip_ctrl.sv
// drrip_ctrl: sequencing state machine for request handling, reset clearing and decay sweep
// depends on drrip_pkg
`timescale 1ns / 1ps

module drrip_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               req_cmd,
   input  drrip_pkg::sts_type sts,
   output drrip_pkg::ctl_type ctl
);
   import drrip_pkg::*;

   typedef enum logic [7:0] {
      S_INIT   = 8'b0000_0001, // clear sweep after reset
      S_IDLE   = 8'b0000_0010,
      S_READ   = 8'b0000_0100,
      S_LATCH  = 8'b0000_1000,
      S_AGE    = 8'b0001_0000,
      S_COMMIT = 8'b0010_0000,
      S_SW_RD  = 8'b0100_0000,
      S_SW_WR  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      cmd_ff, cmd_in;

   assign rsp_valid = out_valid_ff;
   // output register parts the sides: a waiting response does not block intake
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      ctl          = '0;
      unique case (state_ff)
         S_INIT: begin
            ctl.sweep_wr = 1'b1;
            ctl.sweep_inc = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               ctl.capture = 1'b1;
               ctl.rd_row  = 1'b1;
               cmd_in      = req_cmd;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            ctl.latch_row = 1'b1;
            state_in = S_LATCH;
         end
         S_LATCH: begin
            if (cmd_ff == CmdVictim && !sts.found) begin
               state_in = S_AGE;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_AGE: begin
            ctl.age = 1'b1;
            state_in = S_LATCH;
         end
         S_COMMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               ctl.commit   = 1'b1;
               ctl.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = sts.decay_due ? S_SW_RD : S_IDLE;
            end
         end
         S_SW_RD: begin
            ctl.sweep_rd = 1'b1;
            state_in = S_SW_WR;
         end
         S_SW_WR: begin
            ctl.sweep_wr  = 1'b1;
            ctl.sweep_inc = 1'b1;
            state_in = sts.sweep_last ? S_IDLE : S_SW_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         out_valid_ff <= 1'b0;
         cmd_ff       <= CmdVictim;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cmd_ff       <= cmd_in;
      end
   end
endmodule

FILE: rtl/drrip_dp.sv
// drrip_dp: row memories, victim search, aging, selector and decay counters
// depends on drrip_pkg and drrip_ram
`timescale 1ns / 1ps

module drrip_dp (
   input  logic                clock,
   input  logic                reset,
   input  drrip_pkg::req_type  req_data,
   input  logic                csr_we,
   input  logic [15:0]         csr_data,
   input  drrip_pkg::ctl_type  ctl,
   output drrip_pkg::sts_type  sts,
   output drrip_pkg::rsp_type  rsp_data
);
   import drrip_pkg::*;

   req_type              req_ff;
   logic [RowBits-1:0]   rrpv_ff, rrpv_in;
   logic [RowBits-1:0]   live_ff;
   logic [SelectorBits-1:0] psel_ff, psel_in;
   logic [15:0]          fill_ff, fill_in;
   logic [15:0]          interval_ff;
   logic [SetBits-1:0]   sweep_ff;
   logic                 sweeping_ff;
   rsp_type              out_ff, out_in;

   logic [RowBits-1:0]   rrpv_rd, live_rd, rrpv_wd, live_wd;
   logic                 rrpv_we, live_we;
   logic [SetBits-1:0]   addr;

   // sweep uses sweep address; a sweep write without a preceding read is reset clearing
   assign addr = (ctl.sweep_rd || ctl.sweep_wr) ? sweep_ff : req_ff.set_index;

   drrip_ram #(.Width(RowBits), .Depth(NumSets)) u_rrpv (
      .clock(clock), .wr_en(rrpv_we),
      .addr(ctl.rd_row ? req_data.set_index : addr),
      .wr_data(rrpv_wd), .rd_data(rrpv_rd));

   drrip_ram #(.Width(RowBits), .Depth(NumSets)) u_live (
      .clock(clock), .wr_en(live_we),
      .addr(ctl.rd_row ? req_data.set_index : addr),
      .wr_data(live_wd), .rd_data(live_rd));

   // victim search over latched row
   logic [WayBits-1:0] dead_way, max_way;
   logic               dead_hit, max_hit;
   always_comb begin
      dead_way = '0;
      dead_hit = 1'b0;
      max_way  = '0;
      max_hit  = 1'b0;
      for (int w = NumWays - 1; w >= 0; w--) begin
         if (live_ff[2*w +: 2] == 2'd0) begin
            dead_way = WayBits'(w);
            dead_hit = 1'b1;
         end
         if (rrpv_ff[2*w +: 2] == RrpvMax) begin
            max_way = WayBits'(w);
            max_hit = 1'b1;
         end
      end
   end

   logic is_srrip_lead, is_brrip_lead, use_srrip;
   logic [1:0] brrip_val, ins_val;
   logic [1:0] cur_live;
   logic [15:0] fill_inc;
   logic        is_fill, decay_now;

   assign is_srrip_lead = req_ff.set_index < SetBits'(LeaderSets);
   assign is_brrip_lead = !is_srrip_lead &&
                          ({1'b0, req_ff.set_index} >= (SetBits+1)'(NumSets - LeaderSets));
   assign use_srrip = is_srrip_lead || (!is_brrip_lead && psel_ff >= PselHalf);
   assign brrip_val = (req_ff.random_draw == 5'd0) ? NearInsert : RrpvMax;
   assign ins_val   = use_srrip ? 2'd0 : brrip_val;
   assign cur_live  = live_ff[2*req_ff.way_index +: 2];
   assign is_fill   = req_ff.cmd == CmdUpdate && !req_ff.hit;
   assign fill_inc  = fill_ff + 16'd1;
   assign decay_now = is_fill && (fill_inc == interval_ff);

   assign sts.found      = dead_hit || max_hit;
   assign sts.decay_due  = decay_now;
   assign sts.sweep_last = sweep_ff == SetBits'(NumSets - 1);

   always_comb begin
      rrpv_in = rrpv_ff;
      if (ctl.latch_row) begin
         rrpv_in = rrpv_rd;
      end else if (ctl.age) begin
         for (int w = 0; w < NumWays; w++) begin
            if (rrpv_ff[2*w +: 2] != RrpvMax) begin
               rrpv_in[2*w +: 2] = rrpv_ff[2*w +: 2] + 2'd1;
            end
         end
      end
   end

   // write-back data
   always_comb begin
      rrpv_wd = rrpv_ff;
      live_wd = live_ff;
      rrpv_we = 1'b0;
      live_we = 1'b0;
      if (ctl.sweep_wr) begin
         live_we = 1'b1;
         rrpv_we = sweeping_ff ? 1'b0 : 1'b1;
         if (sweeping_ff) begin
            for (int w = 0; w < NumWays; w++) begin
               live_wd[2*w +: 2] = (live_rd[2*w +: 2] == 2'd0) ? 2'd0
                                   : live_rd[2*w +: 2] - 2'd1;
            end
         end else begin
            live_wd = {NumWays{LiveMax}};
            rrpv_wd = {NumWays{RrpvMax}};
         end
      end else if (ctl.commit) begin
         rrpv_we = 1'b1;
         live_we = 1'b1;
         if (req_ff.cmd == CmdUpdate) begin
            if (req_ff.hit) begin
               rrpv_wd[2*req_ff.way_index +: 2] = 2'd0;
               live_wd[2*req_ff.way_index +: 2] =
                  (cur_live == LiveMax) ? LiveMax : cur_live + 2'd1;
            end else begin
               rrpv_wd[2*req_ff.way_index +: 2] = ins_val;
               live_wd[2*req_ff.way_index +: 2] = LiveMax;
            end
         end
      end
   end

   always_comb begin
      psel_in = psel_ff;
      fill_in = fill_ff;
      out_in  = out_ff;
      if (ctl.commit && req_ff.cmd == CmdUpdate) begin
         if (req_ff.hit) begin
            if (is_srrip_lead && psel_ff != PselMax) psel_in = psel_ff + 1'b1;
            else if (is_brrip_lead && psel_ff != '0) psel_in = psel_ff - 1'b1;
         end else begin
            fill_in = decay_now ? 16'd0 : fill_inc;
         end
      end
      if (ctl.load_out) begin
         out_in.victim_way      = '0;
         out_in.victim_was_dead = 1'b0;
         out_in.policy_select   = psel_in;
         if (req_ff.cmd == CmdVictim) begin
            out_in.victim_way      = dead_hit ? dead_way : max_way;
            out_in.victim_was_dead = dead_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psel_ff     <= PselHalf;
         fill_ff     <= '0;
         interval_ff <= DecayReset;
         sweep_ff    <= '0;
         sweeping_ff <= 1'b0;
      end else begin
         psel_ff <= psel_in;
         fill_ff <= fill_in;
         if (csr_we) interval_ff <= csr_data;
         if (ctl.sweep_inc) sweep_ff <= sweep_ff + 1'b1;
         if (ctl.sweep_rd) sweeping_ff <= 1'b1;
         else if (ctl.sweep_inc && sts.sweep_last) sweeping_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) req_ff <= req_data;
      if (ctl.latch_row) live_ff <= live_rd;
      rrpv_ff <= rrpv_in;
      out_ff  <= out_in;
   end

   assign rsp_data = out_ff;
endmodule

FILE: rtl/drrip_dead_block_replacement.sv
// drrip_dead_block_replacement: top level of the drrip replacement block
// depends on drrip_pkg, drrip_if, drrip_ctrl, drrip_dp
`timescale 1ns / 1ps
//
// usage
//   req channel: one request per set access, cmd 0 asks for a victim way,
//   cmd 1 reports a hit (hit=1) or a fill (hit=0) of way_index
//   rsp channel: exactly one response per request, in order, carrying the
//   victim way, the dead-block flag and the set-dueling selector
//   csr channel: writes the fill count between decays; always ready, write only when idle
// sequencing
//   one request at a time through the single row port of two set-wide rams
//   update: row read, latch, then commit, which loads the response register;
//   commit waits while an earlier response is still untaken
//   victim: adds an aging round (age, then latch) while no victim is found,
//   at most 3 rounds; a fill that reaches the decay interval adds a sweep that
//   reads and writes every set in turn, during which no request is taken
// reset
//   a clearing pass writes all 2048 rows before req_ready rises
// stall
//   a response waits in its output register; the next request may be accepted
//   meanwhile but cannot complete until the response is taken
//
module drrip_dead_block_replacement (
   input logic       clock,
   input logic       reset,
   drrip_req_if.sink req,
   drrip_rsp_if.source rsp,
   drrip_csr_if.sink csr
);
   import drrip_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // config register always takes writes
   assign csr.ready = 1'b1;

   drrip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .req_cmd   (req.data.cmd),
      .sts       (sts),
      .ctl       (ctl)
   );

   drrip_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req.data),
      .csr_we   (csr.valid),
      .csr_data (csr.data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_data (rsp.data)
   );
endmodule

FILE: rtl/drrip_checker.sv
// drrip_checker: port-level assertions for the drrip replacement block
// no dependencies; bound to drrip_dead_block_replacement
`timescale 1ns / 1ps

module drrip_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   // a response never rises right after a request is accepted
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response too early");

   // one request at a time: accept never on back-to-back cycles
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted twice in a row");

   // response holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped");

   // not ready just after reset release, as clearing starts
   a_reset_busy: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !req_ready)
      else $error("ready during clearing");
endmodule

bind drrip_dead_block_replacement drrip_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);
